@@ design/apss_pkg.sv @@
// Package for the ATA PIO sector sequencer: codes, widths and the item
// descriptor passed from the job controller to the result emitter.
// No dependencies.
package apss_pkg;

    // Sector geometry
    localparam int WORDS_PER_SECTOR = 128;
    localparam int WIDX_W = (WORDS_PER_SECTOR > 1) ? $clog2(WORDS_PER_SECTOR) : 1;

    // Input item modes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_STATUS = 2'd1;
    localparam logic [1:0] MODE_DATA   = 2'd2;

    // Start directions
    localparam logic [1:0] DIR_READ  = 2'd0;
    localparam logic [1:0] DIR_WRITE = 2'd1;

    // Result kinds
    localparam logic [1:0] KIND_REG      = 2'd0;
    localparam logic [1:0] KIND_TO_DEV   = 2'd1;
    localparam logic [1:0] KIND_TO_HOST  = 2'd2;
    localparam logic [1:0] KIND_COMPLETE = 2'd3;

    // Completion outcomes
    localparam logic [1:0] OUTCOME_OK      = 2'd0;
    localparam logic [1:0] OUTCOME_BAD_DIR = 2'd1;
    localparam logic [1:0] OUTCOME_BAD_LBA = 2'd2;
    localparam logic [1:0] OUTCOME_DEV_ERR = 2'd3;

    // Task register bytes
    localparam logic [7:0] DEV_BASE  = 8'hE0;
    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam int         REG_COUNT = 6;

    // Status bits
    localparam int STATUS_BSY = 7;
    localparam int STATUS_DRQ = 3;

    // Job phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_POLL = 2'd1;
    localparam logic [1:0] PH_XFER = 2'd2;

    // Result burst shapes caused by one input item
    localparam logic [1:0] BURST_NONE  = 2'd0;
    localparam logic [1:0] BURST_START = 2'd1;
    localparam logic [1:0] BURST_ONE   = 2'd2;
    localparam logic [1:0] BURST_PAIR  = 2'd3;

    typedef logic [REG_COUNT-1:0][7:0] reg_bytes_t;

    typedef struct packed {
        logic [1:0]  burst;
        logic [1:0]  kind;
        logic [1:0]  outcome;
        logic [31:0] word;
        reg_bytes_t  bytes;
    } desc_t;

    // Number of results in a burst
    function automatic logic [2:0] burst_len(input logic [1:0] burst);
        logic [2:0] n;
        unique case (burst)
            BURST_START: n = 3'(REG_COUNT);
            BURST_ONE:   n = 3'd1;
            BURST_PAIR:  n = 3'd2;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

@@ design/apss_ctrl.sv @@
// Job controller of the ATA PIO sector sequencer: phase, direction,
// sector and word counters, and the result descriptor for each item.
// Depends on apss_pkg.
module apss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [1:0]          mode,
    input  logic                drive,
    input  logic [1:0]          direction,
    input  logic [31:0]         lba,
    input  logic [7:0]          sector_count,
    input  logic [7:0]          status,
    input  logic [31:0]         data_word,
    output apss_pkg::desc_t     desc
);

    logic [1:0]                  phase_reg, phase_next;
    logic                        is_write_reg, is_write_next;
    logic [7:0]                  sectors_reg, sectors_next;
    logic [apss_pkg::WIDX_W-1:0] widx_reg, widx_next;

    logic       bsy;
    logic       drq;
    logic [1:0] word_kind;

    assign bsy       = status[apss_pkg::STATUS_BSY];
    assign drq       = status[apss_pkg::STATUS_DRQ];
    assign word_kind = is_write_reg ? apss_pkg::KIND_TO_DEV : apss_pkg::KIND_TO_HOST;

    // Decode the item against the job state
    always_comb
    begin
        phase_next    = phase_reg;
        is_write_next = is_write_reg;
        sectors_next  = sectors_reg;
        widx_next     = widx_reg;
        desc          = '0;
        unique case (mode)
            apss_pkg::MODE_START:
            begin
                if (phase_reg == apss_pkg::PH_IDLE)
                begin
                    if (direction[1])
                    begin
                        desc.burst   = apss_pkg::BURST_ONE;
                        desc.kind    = apss_pkg::KIND_COMPLETE;
                        desc.outcome = apss_pkg::OUTCOME_BAD_DIR;
                    end
                    else if (lba[31:28] != 4'd0)
                    begin
                        desc.burst   = apss_pkg::BURST_ONE;
                        desc.kind    = apss_pkg::KIND_COMPLETE;
                        desc.outcome = apss_pkg::OUTCOME_BAD_LBA;
                    end
                    else
                    begin
                        desc.burst    = apss_pkg::BURST_START;
                        desc.kind     = apss_pkg::KIND_REG;
                        desc.bytes[0] = apss_pkg::DEV_BASE | {3'd0, drive, lba[27:24]};
                        desc.bytes[1] = sector_count;
                        desc.bytes[2] = lba[7:0];
                        desc.bytes[3] = lba[15:8];
                        desc.bytes[4] = lba[23:16];
                        desc.bytes[5] = (direction == apss_pkg::DIR_WRITE) ?
                                        apss_pkg::CMD_WRITE : apss_pkg::CMD_READ;
                        is_write_next = direction[0];
                        sectors_next  = sector_count;
                        widx_next     = '0;
                        phase_next    = apss_pkg::PH_POLL;
                    end
                end
            end
            apss_pkg::MODE_STATUS:
            begin
                if (phase_reg == apss_pkg::PH_POLL && !bsy)
                begin
                    if (drq)
                    begin
                        phase_next = apss_pkg::PH_XFER;
                        widx_next  = '0;
                    end
                    else
                    begin
                        desc.burst   = apss_pkg::BURST_ONE;
                        desc.kind    = apss_pkg::KIND_COMPLETE;
                        desc.outcome = is_write_reg ? apss_pkg::OUTCOME_OK :
                                                      apss_pkg::OUTCOME_DEV_ERR;
                        phase_next   = apss_pkg::PH_IDLE;
                    end
                end
            end
            apss_pkg::MODE_DATA:
            begin
                if (phase_reg == apss_pkg::PH_XFER)
                begin
                    desc.word = data_word;
                    if (widx_reg != apss_pkg::WIDX_W'(apss_pkg::WORDS_PER_SECTOR - 1))
                    begin
                        // Word inside the sector
                        desc.burst = apss_pkg::BURST_ONE;
                        desc.kind  = word_kind;
                        widx_next  = widx_reg + apss_pkg::WIDX_W'(1);
                    end
                    else
                    begin
                        // Last word of a sector
                        widx_next    = '0;
                        sectors_next = sectors_reg - 8'd1;
                        if (!is_write_reg && sectors_reg == 8'd1)
                        begin
                            desc.burst = apss_pkg::BURST_PAIR;
                            desc.kind  = apss_pkg::KIND_TO_HOST;
                            phase_next = apss_pkg::PH_IDLE;
                        end
                        else
                        begin
                            desc.burst = apss_pkg::BURST_ONE;
                            desc.kind  = word_kind;
                            phase_next = apss_pkg::PH_POLL;
                        end
                    end
                end
            end
            default:
            begin
                desc = '0;
            end
        endcase
    end

    // Commit the job state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= apss_pkg::PH_IDLE;
            is_write_reg <= 1'b0;
            sectors_reg  <= 8'd0;
            widx_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            is_write_reg <= is_write_next;
            sectors_reg  <= sectors_next;
            widx_reg     <= widx_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("phase register holds an unused code");

    a_xfer_from_poll: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(phase_reg == apss_pkg::PH_XFER) |-> $past(phase_reg) == apss_pkg::PH_POLL)
        else $error("transfer opened outside polling");

    a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && desc.burst == apss_pkg::BURST_START) |=> phase_reg == apss_pkg::PH_POLL)
        else $error("accepted start did not enter polling");
`endif

endmodule

@@ design/ata_pio_sector_sequencer_unit.sv @@
// Top level of the ATA PIO sector sequencer: input handshake, job
// controller instance and the registered result emitter.
// Depends on apss_pkg and apss_ctrl.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  input   | in_valid / in_ready  | mode drive direction lba sector_count status
//          |                      | data_word
//  output  | out_valid/out_ready  | kind reg_select reg_value word_out outcome last
//
// An item is decoded in the cycle it is accepted; its results come out of the
// result register from the next cycle on, one per cycle while out_ready is high.
// A status item gives at most one result, a data item one, a read's final word
// two (the word and the completion) and a good start six register results.
// A new item is taken in the same cycle the last pending result is taken.
// Reset clears the job state and empties the result register.
module ata_pio_sector_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic        drive,
    input  logic [1:0]  direction,
    input  logic [31:0] lba,
    input  logic [7:0]  sector_count,
    input  logic [7:0]  status,
    input  logic [31:0] data_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [2:0]  reg_select,
    output logic [7:0]  reg_value,
    output logic [31:0] word_out,
    output logic [1:0]  outcome,
    output logic        last
);

    apss_pkg::desc_t     desc;
    logic                in_fire;
    logic                out_fire;

    logic [1:0]           burst_reg;
    logic [2:0]           rem_reg;
    logic [2:0]           step_reg;
    logic [1:0]           kind_reg;
    logic [1:0]           outcome_reg;
    logic [31:0]          word_reg;
    apss_pkg::reg_bytes_t bytes_reg;

    assign out_valid = (rem_reg != 3'd0);
    assign last      = (rem_reg == 3'd1);
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = !out_valid || (last && out_ready);
    assign in_fire   = in_valid && in_ready;

    apss_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (in_fire),
        .mode         (mode),
        .drive        (drive),
        .direction    (direction),
        .lba          (lba),
        .sector_count (sector_count),
        .status       (status),
        .data_word    (data_word),
        .desc         (desc)
    );

    // Load a new burst or advance through the pending one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg <= apss_pkg::BURST_NONE;
            rem_reg   <= 3'd0;
            step_reg  <= 3'd0;
        end
        else if (in_fire)
        begin
            burst_reg <= desc.burst;
            rem_reg   <= apss_pkg::burst_len(desc.burst);
            step_reg  <= 3'd0;
        end
        else if (out_fire)
        begin
            rem_reg  <= rem_reg - 3'd1;
            step_reg <= step_reg + 3'd1;
        end
    end

    // Hold the payload of the pending burst
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg    <= desc.kind;
            outcome_reg <= desc.outcome;
            word_reg    <= desc.word;
            bytes_reg   <= desc.bytes;
        end
    end

    // Select the current result of the burst
    always_comb
    begin
        kind       = 2'd0;
        reg_select = 3'd0;
        reg_value  = 8'd0;
        word_out   = 32'd0;
        outcome    = 2'd0;
        unique case (burst_reg)
            apss_pkg::BURST_START:
            begin
                kind       = apss_pkg::KIND_REG;
                reg_select = step_reg;
                unique case (step_reg)
                    3'd0:    reg_value = bytes_reg[0];
                    3'd1:    reg_value = bytes_reg[1];
                    3'd2:    reg_value = bytes_reg[2];
                    3'd3:    reg_value = bytes_reg[3];
                    3'd4:    reg_value = bytes_reg[4];
                    3'd5:    reg_value = bytes_reg[5];
                    default: reg_value = 8'd0;
                endcase
            end
            apss_pkg::BURST_ONE:
            begin
                kind     = kind_reg;
                word_out = word_reg;
                outcome  = outcome_reg;
            end
            apss_pkg::BURST_PAIR:
            begin
                if (step_reg == 3'd0)
                begin
                    kind     = apss_pkg::KIND_TO_HOST;
                    word_out = word_reg;
                end
                else
                begin
                    kind    = apss_pkg::KIND_COMPLETE;
                    outcome = apss_pkg::OUTCOME_OK;
                end
            end
            default:
            begin
                kind = 2'd0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_burst_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !last) |=> out_valid)
        else $error("result burst broke off early");

    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && burst_reg == apss_pkg::BURST_START) |->
        (step_reg + rem_reg == 3'(apss_pkg::REG_COUNT)))
        else $error("task register burst lost its place");

    a_no_accept_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> !in_ready)
        else $error("input taken while results were still pending");
`endif

endmodule
